[sv/mpm_pkg.sv]
// Package: shared codes, widths and sequencer states of the pattern match predictor.
`default_nettype none

package mpm_pkg;

  localparam int OPCODE_W  = 2;
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 5;
  localparam int CFG_W     = 6;
  localparam int BUCKET_W  = 7;

  localparam logic [OPCODE_W-1:0] OP_LOAD_BYTE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_LEN  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DATA      = 2'd2;

  localparam logic [CFG_W-1:0] MIN_CONTEXT_RESET = 6'd2;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LEN_WR = 7'b0000010,
    ST_ENT_RD = 7'b0000100,
    ST_PAT_RD = 7'b0001000,
    ST_NXT_RD = 7'b0010000,
    ST_EVAL   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

[sv/mpm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/multi_pattern_match_predictor.sv]
// Top level: multi-pattern dictionary match predictor with memory-held match state.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+---------------------------
//  in      | opcode pattern_index position  | in_valid / in_ready
//          | value                          |
//  out     | expectation_valid expected_byte| out_valid / out_ready
//          | best_pattern several_agree     |
//          | context_bucket                 |
//  cfg     | cfg_wdata (min_context)        | cfg_we, no wait
//
// In a data byte's walk each pattern costs three reads of the pattern store port (first
// byte, current byte, next byte). A pattern byte load is written when it is accepted; a
// length load is a read-modify-write of the pattern's entry.
// Reset is synchronous; it clears the per-pattern valid bits, so match lengths read 0.
// A finished result waits in the output register; the next transaction is accepted
// meanwhile, and a data byte stalls only at the end of its walk while that slot is full.
`default_nettype none

module multi_pattern_match_predictor #(
  parameter int PATTERN_COUNT   = 256,
  parameter int MAX_PATTERN_LEN = 32,
  parameter int PATTERN_BUCKETS = 16,
  parameter int LENGTH_BUCKETS  = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mpm_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire logic [mpm_pkg::BYTE_W-1:0]     in_pattern_index,
  input  wire logic [mpm_pkg::POS_W-1:0]      in_position,
  input  wire logic [mpm_pkg::BYTE_W-1:0]     in_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_expectation_valid,
  output logic      [mpm_pkg::BYTE_W-1:0]     out_expected_byte,
  output logic      [mpm_pkg::BYTE_W-1:0]     out_best_pattern,
  output logic                                out_several_agree,
  output logic      [mpm_pkg::BUCKET_W-1:0]   out_context_bucket,
  input  wire logic                           cfg_we,
  input  wire logic [mpm_pkg::CFG_W-1:0]      cfg_wdata
);

  import mpm_pkg::*;

  localparam int IDX_W    = PATTERN_COUNT > 1 ? $clog2(PATTERN_COUNT) : 1;
  localparam int LEN_W    = $clog2(MAX_PATTERN_LEN + 1);
  localparam int ENT_W    = 2 * LEN_W;
  localparam int ST_DEPTH = PATTERN_COUNT * MAX_PATTERN_LEN;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam int CMP_W    = LEN_W > CFG_W ? LEN_W : CFG_W;
  localparam int PB_W     = PATTERN_BUCKETS > 1 ? $clog2(PATTERN_BUCKETS) : 1;
  localparam int ACC_W    = IDX_W + 1;
  localparam int PB_Q     = PATTERN_BUCKETS / PATTERN_COUNT;
  localparam int PB_R     = PATTERN_BUCKETS % PATTERN_COUNT;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PATTERN_COUNT - 1);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PATTERN_LEN);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]         min_ctx_r;
  logic [PATTERN_COUNT-1:0] vld_r, vld_nxt;

  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [ST_AW-1:0]  base_r, base_nxt;
  logic [PB_W-1:0]   pb_r, pb_nxt;
  logic [IDX_W-1:0]  acc_r, acc_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;

  logic [IDX_W-1:0]  lw_idx_r, lw_idx_nxt;
  logic [LEN_W-1:0]  lw_len_r, lw_len_nxt;

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  m_r, m_nxt;
  logic              first_r, first_nxt;

  logic              eval_pend_r, eval_pend_nxt;
  logic              cand_r, cand_nxt;
  logic [LEN_W-1:0]  cand_len_r, cand_len_nxt;
  logic [IDX_W-1:0]  cand_idx_r, cand_idx_nxt;
  logic [PB_W-1:0]   cand_pb_r, cand_pb_nxt;

  logic              found_r, found_nxt;
  logic              conflict_r, conflict_nxt;
  logic              several_r, several_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [PB_W-1:0]   best_pb_r, best_pb_nxt;
  logic [BYTE_W-1:0] want_r, want_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ev_r, out_ev_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic [BYTE_W-1:0]   out_pat_r, out_pat_nxt;
  logic                out_sev_r, out_sev_nxt;
  logic [BUCKET_W-1:0] out_bkt_r, out_bkt_nxt;

  logic              ent_we;
  logic [IDX_W-1:0]  ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  logic              st_we;
  logic [ST_AW-1:0]  st_waddr, st_raddr;
  logic [BYTE_W-1:0] st_rdata;

  logic              in_acc, idx_ok, pos_ok;
  logic [LEN_W-1:0]  ent_len, ent_m;
  logic [LEN_W-1:0]  m_new;
  logic              cand_now;
  logic [CMP_W-1:0]  minc;
  logic              do_eval;
  logic [ACC_W-1:0]  acc_sum;
  logic [CMP_W-1:0]  len_diff;
  logic [BUCKET_W-1:0] len_bkt;
  logic              emit_ok;

  mpm_ram #(.WIDTH(ENT_W), .DEPTH(PATTERN_COUNT)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  mpm_ram #(.WIDTH(BYTE_W), .DEPTH(ST_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_value),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign idx_ok   = int'(in_pattern_index) < PATTERN_COUNT;
  assign pos_ok   = int'(in_position) < MAX_PATTERN_LEN;

  assign minc     = (min_ctx_r == '0) ? CMP_W'(1) : CMP_W'(min_ctx_r);
  assign ent_len  = ent_rdata[ENT_W-1:LEN_W];
  assign ent_m    = vld_r[i_r] ? ent_rdata[LEN_W-1:0] : '0;

  always_comb begin
    if ((m_r < len_r) && (st_rdata == byte_r)) begin
      m_new = m_r + LEN_W'(1);
    end else begin
      m_new = LEN_W'(first_r);
    end
    if (m_new >= len_r) begin
      m_new = LEN_W'(first_r);
    end
  end

  assign cand_now = (CMP_W'(m_new) >= minc) && (m_new < len_r);
  assign do_eval  = eval_pend_r && ((state_r == ST_ENT_RD) || (state_r == ST_EVAL));
  assign acc_sum  = ACC_W'(acc_r) + ACC_W'(PB_R);
  assign emit_ok  = !out_valid_r || out_ready;

  assign len_diff = CMP_W'(best_len_r) - minc;
  assign len_bkt  = (len_diff >= CMP_W'(LENGTH_BUCKETS - 1)) ?
                    BUCKET_W'(LENGTH_BUCKETS - 1) : BUCKET_W'(len_diff);

  always_comb begin
    ent_raddr = (state_r == ST_IDLE) ? IDX_W'(in_pattern_index) : i_r;
    ent_we    = 1'b0;
    ent_waddr = i_r;
    ent_wdata = {len_r, m_new};
    st_we     = in_acc && (in_opcode == OP_LOAD_BYTE) && idx_ok && pos_ok;
    st_waddr  = ST_AW'(32'(in_pattern_index) * MAX_PATTERN_LEN + 32'(in_position));
    st_raddr  = base_r;
    unique case (state_r)
      ST_LEN_WR: begin
        ent_we    = 1'b1;
        ent_waddr = lw_idx_r;
        ent_wdata = {lw_len_r, (vld_r[lw_idx_r] ? ent_rdata[LEN_W-1:0] : LEN_W'(0))};
      end
      ST_PAT_RD: begin
        st_raddr = base_r + ST_AW'((ent_m < ent_len) ? ent_m : LEN_W'(0));
      end
      ST_NXT_RD: begin
        ent_we   = 1'b1;
        st_raddr = base_r + ST_AW'(cand_now ? m_new : LEN_W'(0));
      end
      default: begin
        st_raddr = base_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    i_nxt         = i_r;
    base_nxt      = base_r;
    pb_nxt        = pb_r;
    acc_nxt       = acc_r;
    byte_nxt      = byte_r;
    lw_idx_nxt    = lw_idx_r;
    lw_len_nxt    = lw_len_r;
    len_nxt       = len_r;
    m_nxt         = m_r;
    first_nxt     = first_r;
    eval_pend_nxt = eval_pend_r;
    cand_nxt      = cand_r;
    cand_len_nxt  = cand_len_r;
    cand_idx_nxt  = cand_idx_r;
    cand_pb_nxt   = cand_pb_r;
    found_nxt     = found_r;
    conflict_nxt  = conflict_r;
    several_nxt   = several_r;
    best_len_nxt  = best_len_r;
    best_idx_nxt  = best_idx_r;
    best_pb_nxt   = best_pb_r;
    want_nxt      = want_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ev_nxt    = out_ev_r;
    out_byte_nxt  = out_byte_r;
    out_pat_nxt   = out_pat_r;
    out_sev_nxt   = out_sev_r;
    out_bkt_nxt   = out_bkt_r;

    if (do_eval) begin
      eval_pend_nxt = 1'b0;
      if (cand_r) begin
        if (!found_r || (cand_len_r > best_len_r)) begin
          found_nxt    = 1'b1;
          best_len_nxt = cand_len_r;
          best_idx_nxt = cand_idx_r;
          best_pb_nxt  = cand_pb_r;
          want_nxt     = st_rdata;
          several_nxt  = 1'b0;
          conflict_nxt = 1'b0;
        end else if (cand_len_r == best_len_r) begin
          if (st_rdata == want_r) begin
            several_nxt = 1'b1;
          end else begin
            conflict_nxt = 1'b1;
          end
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_opcode == OP_DATA) begin
            state_nxt     = ST_ENT_RD;
            byte_nxt      = in_value;
            i_nxt         = '0;
            base_nxt      = '0;
            pb_nxt        = '0;
            acc_nxt       = '0;
            found_nxt     = 1'b0;
            conflict_nxt  = 1'b0;
            several_nxt   = 1'b0;
            eval_pend_nxt = 1'b0;
          end else if ((in_opcode == OP_LOAD_LEN) && idx_ok) begin
            state_nxt  = ST_LEN_WR;
            lw_idx_nxt = IDX_W'(in_pattern_index);
            lw_len_nxt = (int'(in_value) > MAX_PATTERN_LEN) ? MAX_LEN : LEN_W'(in_value);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LEN_WR: begin
        vld_nxt[lw_idx_r] = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_ENT_RD: begin
        state_nxt = ST_PAT_RD;
      end
      ST_PAT_RD: begin
        len_nxt   = ent_len;
        m_nxt     = ent_m;
        first_nxt = (st_rdata == byte_r);
        state_nxt = ST_NXT_RD;
      end
      ST_NXT_RD: begin
        vld_nxt[i_r]  = 1'b1;
        eval_pend_nxt = 1'b1;
        cand_nxt      = cand_now;
        cand_len_nxt  = m_new;
        cand_idx_nxt  = i_r;
        cand_pb_nxt   = pb_r;
        i_nxt         = i_r + IDX_W'(1);
        base_nxt      = base_r + ST_AW'(MAX_PATTERN_LEN);
        if (acc_sum >= ACC_W'(PATTERN_COUNT)) begin
          acc_nxt = IDX_W'(acc_sum - ACC_W'(PATTERN_COUNT));
          pb_nxt  = pb_r + PB_W'(PB_Q) + PB_W'(1);
        end else begin
          acc_nxt = IDX_W'(acc_sum);
          pb_nxt  = pb_r + PB_W'(PB_Q);
        end
        state_nxt = (i_r == LAST_IDX) ? ST_EVAL : ST_ENT_RD;
      end
      ST_EVAL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = found_r && !conflict_r;
          out_byte_nxt  = (found_r && !conflict_r) ? want_r : '0;
          out_pat_nxt   = (found_r && !conflict_r) ? BYTE_W'(best_idx_r) : '0;
          out_sev_nxt   = found_r && !conflict_r && several_r;
          out_bkt_nxt   = (found_r && !conflict_r) ?
                          BUCKET_W'(BUCKET_W'(best_pb_r) * BUCKET_W'(LENGTH_BUCKETS) + len_bkt)
                          : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_ctx_r   <= MIN_CONTEXT_RESET;
      vld_r       <= '0;
      eval_pend_r <= 1'b0;
      found_r     <= 1'b0;
      conflict_r  <= 1'b0;
      several_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      eval_pend_r <= eval_pend_nxt;
      found_r     <= found_nxt;
      conflict_r  <= conflict_nxt;
      several_r   <= several_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_ctx_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    base_r     <= base_nxt;
    pb_r       <= pb_nxt;
    acc_r      <= acc_nxt;
    byte_r     <= byte_nxt;
    lw_idx_r   <= lw_idx_nxt;
    lw_len_r   <= lw_len_nxt;
    len_r      <= len_nxt;
    m_r        <= m_nxt;
    first_r    <= first_nxt;
    cand_r     <= cand_nxt;
    cand_len_r <= cand_len_nxt;
    cand_idx_r <= cand_idx_nxt;
    cand_pb_r  <= cand_pb_nxt;
    best_len_r <= best_len_nxt;
    best_idx_r <= best_idx_nxt;
    best_pb_r  <= best_pb_nxt;
    want_r     <= want_nxt;
    out_ev_r   <= out_ev_nxt;
    out_byte_r <= out_byte_nxt;
    out_pat_r  <= out_pat_nxt;
    out_sev_r  <= out_sev_nxt;
    out_bkt_r  <= out_bkt_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_expectation_valid = out_ev_r;
  assign out_expected_byte     = out_byte_r;
  assign out_best_pattern      = out_pat_r;
  assign out_several_agree     = out_sev_r;
  assign out_context_bucket    = out_bkt_r;

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && emit_ok |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not loaded on emit");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NXT_RD) |=> (state_r == ST_ENT_RD) || (state_r == ST_EVAL))
    else $error("pattern walk left its sequence");

  a_last_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> eval_pend_r)
    else $error("last pattern reached final evaluation without a pending candidate");

  a_best_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) && found_r |-> (CMP_W'(best_len_r) >= minc))
    else $error("best match shorter than minimum context");

endmodule

`default_nettype wire
